FILE: sv/r2fft_pkg.sv
// Shared types, constants and the twiddle generator for the radix-2 FFT/IFFT unit.
`default_nettype none

package r2fft_pkg;

   localparam int JOB_M_BITS   = 4;
   localparam int JOB_CNT_BITS = 13;

   localparam int CSR_INVERSE     = 0;
   localparam int CSR_LOG2_POINTS = 1;

   localparam int SAT_MAX = 8388607;
   localparam int SAT_MIN = -8388608;

   localparam longint unsigned PI_Q30 = 64'd3373259426;

   // One transform request handed from the load side to the compute side.
   typedef struct packed {
      logic [JOB_M_BITS-1:0]   m;
      logic                    inv;
      logic [JOB_CNT_BITS-1:0] used;
   } job_type;

   typedef struct packed {
      logic take;
      logic unlock;
   } back_status_type;

   // Clamp a Q30 value to [0, 1.0], round half up to tbits-1 fraction bits.
   function automatic longint to_twid(longint v, int tbits);
      longint w;
      longint lim;
      longint r;
      int     f;
      int     s;
      f   = tbits - 1;
      s   = 30 - f;
      lim = (64'sd1 <<< f) - 64'sd1;
      w   = v;
      if (w < 0) w = 0;
      if (w > (64'sd1 <<< 30)) w = 64'sd1 <<< 30;
      r = (w + (64'sd1 <<< (s - 1))) >>> s;
      return (r > lim) ? lim : r;
   endfunction

   // Shift-and-subtract division; it only runs while the twiddle table is built.
   function automatic longint unsigned udiv(longint unsigned num, longint unsigned den);
      longint unsigned q;
      longint unsigned r;
      q = '0;
      r = '0;
      for (int i = 63; i >= 0; i--) begin
         r = {r[62:0], num[i]};
         if (r >= den) begin
            r    = r - den;
            q[i] = 1'b1;
         end
      end
      return q;
   endfunction

   // Cosine in bits [47:24] and sine in bits [23:0] of 2*pi*k/2^m, evaluated
   // by a fixed Taylor series on an angle quantized to 1/65536 of a turn.
   function automatic logic [47:0] twid_word(int k, int m, int tbits);
      longint unsigned ph;
      longint unsigned q;
      longint unsigned r;
      longint unsigned u;
      longint unsigned a;
      longint unsigned a2;
      longint unsigned ts;
      longint unsigned tc;
      longint unsigned dv;
      longint          ss;
      longint          cs;
      longint          bc;
      longint          bs;
      longint          x;
      longint          y;
      longint          c;
      longint          s;
      ph = (longint'(k) << (16 - m)) & 64'hFFFF;
      q  = ph >> 14;
      r  = ph & 64'h3FFF;
      u  = (r > 64'd8192) ? (64'd16384 - r) : r;
      a  = (u * PI_Q30 + (64'd1 << 14)) >> 15;
      a2 = (a * a + (64'd1 << 29)) >> 30;
      ts = a;
      tc = 64'd1 << 30;
      ss = longint'(a);
      cs = longint'(tc);
      for (int n = 1; n <= 6; n++) begin
         dv = longint'((2 * n) * (2 * n + 1));
         ts = udiv((ts * a2 + (64'd1 << 29)) >> 30, dv);
         dv = longint'((2 * n - 1) * (2 * n));
         tc = udiv((tc * a2 + (64'd1 << 29)) >> 30, dv);
         if ((n & 1) == 1) begin
            ss = ss - longint'(ts);
            cs = cs - longint'(tc);
         end else begin
            ss = ss + longint'(ts);
            cs = cs + longint'(tc);
         end
      end
      if (r > 64'd8192) begin
         bs = cs;
         bc = ss;
      end else begin
         bc = cs;
         bs = ss;
      end
      x = to_twid(bc, tbits);
      y = to_twid(bs, tbits);
      case (q)
         64'd0: begin c = x;  s = y;  end
         64'd1: begin c = -y; s = x;  end
         64'd2: begin c = -x; s = -y; end
         default: begin c = y; s = -x; end
      endcase
      return {24'(c), 24'(s)};
   endfunction

endpackage

`default_nettype wire

FILE: sv/r2fft_ram.sv
// Generic RAM: one write port and two registered read ports.
`default_nettype none

module r2fft_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr_a,
   output logic      [WIDTH-1:0]         rd_data_a,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic      [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
   end

endmodule

`default_nettype wire

FILE: sv/r2fft_front.sv
// Load side: takes samples into the frame store and posts a job on frame end.
`default_nettype none

module r2fft_front import r2fft_pkg::*; #(
   parameter int ML = 6,
   parameter int MW = 3
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic signed [15:0]   req_sample_re,
   input  wire logic signed [15:0]   req_sample_im,
   input  wire logic                 req_frame_end,
   input  wire logic                 cfg_inverse,
   input  wire logic [MW-1:0]        cfg_m,
   input  wire back_status_type      back_st,
   output logic                      job_valid,
   output job_type                   job,
   output logic                      fs_wr_en,
   output logic [ML-1:0]             fs_wr_addr,
   output logic [31:0]               fs_wr_data
);

   logic [ML:0] count_ff, count_in;
   logic        lock_ff, lock_in;
   logic        job_valid_ff, job_valid_in;
   job_type     job_ff, job_in;
   logic [ML:0] points;
   logic        xfer;
   logic        room;

   assign points     = (ML+1)'(1) << cfg_m;
   assign req_ready  = !lock_ff;
   assign xfer       = req_valid && req_ready;
   assign room       = count_ff < points;
   assign fs_wr_en   = xfer && room;
   assign fs_wr_addr = count_ff[ML-1:0];
   assign fs_wr_data = {req_sample_re, req_sample_im};
   assign job_valid  = job_valid_ff;
   assign job        = job_ff;

   // The frame store stays locked from frame end until the compute side has
   // copied it out.
   always_comb begin
      count_in     = count_ff;
      lock_in      = lock_ff;
      job_valid_in = job_valid_ff;
      job_in       = job_ff;
      if (xfer) begin
         if (room) begin
            count_in = count_ff + (ML+1)'(1);
         end
         if (req_frame_end) begin
            count_in     = '0;
            lock_in      = 1'b1;
            job_valid_in = 1'b1;
            job_in.m     = JOB_M_BITS'(cfg_m);
            job_in.inv   = cfg_inverse;
            job_in.used  = JOB_CNT_BITS'(room ? count_ff + (ML+1)'(1) : count_ff);
         end
      end
      if (back_st.take) begin
         job_valid_in = 1'b0;
      end
      if (back_st.unlock) begin
         lock_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         lock_ff      <= 1'b0;
         job_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         lock_ff      <= lock_in;
         job_valid_ff <= job_valid_in;
      end
      job_ff <= job_in;
   end

endmodule

`default_nettype wire

FILE: sv/r2fft_back.sv
// Compute side: bit-reversed copy, in-place butterflies, scaled and saturated emit.
`default_nettype none

module r2fft_back import r2fft_pkg::*; #(
   parameter int ML  = 6,
   parameter int MW  = 3,
   parameter int DW  = 24,
   parameter int TWB = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               job_valid,
   input  wire job_type            job,
   output back_status_type         back_st,
   output logic [ML-1:0]           fs_rd_addr,
   input  wire logic [31:0]        fs_rd_data,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic signed [23:0]      rsp_bin_re,
   output logic signed [23:0]      rsp_bin_im,
   output logic                    rsp_bin_last
);

   localparam int TIW  = (ML > 1) ? ML - 1 : 1;
   localparam int TN   = 1 << TIW;
   localparam int SIW  = (ML > 1) ? $clog2(ML) : 1;
   localparam int F    = TWB - 1;
   localparam int PW   = DW + TWB;
   localparam int SATW = ((DW + 1) > 25) ? DW + 1 : 25;
   localparam logic signed [PW:0]     RND_F = (PW+1)'(1) <<< (F - 1);
   localparam logic signed [SATW-1:0] SMAX  = SATW'(SAT_MAX);
   localparam logic signed [SATW-1:0] SMIN  = SATW'(SAT_MIN);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_COPY  = 4'd1;
   localparam logic [3:0] S_FLUSH = 4'd2;
   localparam logic [3:0] S_BRD   = 4'd3;
   localparam logic [3:0] S_BMUL  = 4'd4;
   localparam logic [3:0] S_BWA   = 4'd5;
   localparam logic [3:0] S_BWB   = 4'd6;
   localparam logic [3:0] S_ERD   = 4'd7;
   localparam logic [3:0] S_ECAP  = 4'd8;
   localparam logic [3:0] S_EOUT  = 4'd9;

   logic [47:0] tw_rom [TN];

   for (genvar g = 0; g < TN; g++) begin : g_tw
      localparam logic [47:0] TV = twid_word(g, ML, TWB);
      assign tw_rom[g] = TV;
   end

   logic [3:0]      state_ff, state_in;
   logic [MW-1:0]   m_ff, m_in;
   logic            inv_ff, inv_in;
   logic [ML:0]     used_ff, used_in;
   logic [ML-1:0]   idx_ff, idx_in;
   logic            cp_pend_ff, cp_pend_in;
   logic [ML-1:0]   cp_idx_ff, cp_idx_in;
   logic [TIW-1:0]  k_ff, k_in;
   logic [SIW-1:0]  sidx_ff, sidx_in;
   logic signed [TWB-1:0] tw_c_ff, tw_c_in, tw_s_ff, tw_s_in;
   logic signed [PW-1:0]  p_rc_ff, p_is_ff, p_rs_ff, p_ic_ff;
   logic signed [DW-1:0]  a_re_ff, a_im_ff, b_re_ff, b_im_ff, b_re_in, b_im_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic signed [23:0] bin_re_ff, bin_re_in, bin_im_ff, bin_im_in;
   logic            bin_last_ff, bin_last_in;

   logic            wk_we;
   logic [ML-1:0]   wk_waddr, wk_ra, wk_rb;
   logic [2*DW-1:0] wk_wdata, wk_da, wk_db;

   logic [ML-1:0]   last_idx;
   logic [TIW-1:0]  k_last;
   logic [ML-1:0]   kx, mask, a_addr, b_addr;
   logic [TIW-1:0]  tw_idx;
   logic signed [DW-1:0] br, bi;
   logic signed [PW:0]   tre_full, tim_full;
   logic signed [DW:0]   t_re, t_im;
   logic signed [DW-1:0] an_re, an_im;
   logic signed [23:0]   e_re, e_im;

   function automatic logic [ML-1:0] bit_rev(logic [ML-1:0] i, logic [MW-1:0] m);
      logic [ML-1:0] r;
      for (int b = 0; b < ML; b++) begin
         r[ML-1-b] = i[b];
      end
      return r >> (ML - int'(m));
   endfunction

   // Inverse scaling by the length with rounding, then 24-bit saturation.
   function automatic logic signed [23:0] finish(logic signed [DW-1:0] v,
                                                 logic inv, logic [MW-1:0] m);
      logic signed [DW:0]     w;
      logic signed [SATW-1:0] x;
      w = (DW+1)'(v);
      if (inv && (m != '0)) begin
         w = (w + ((DW+1)'(1) <<< (int'(m) - 1))) >>> m;
      end
      x = SATW'(w);
      if (x > SMAX) x = SMAX;
      if (x < SMIN) x = SMIN;
      return x[23:0];
   endfunction

   r2fft_ram #(.WIDTH(2 * DW), .DEPTH(1 << ML)) u_work (
      .clock     (clock),
      .wr_en     (wk_we),
      .wr_addr   (wk_waddr),
      .wr_data   (wk_wdata),
      .rd_addr_a (wk_ra),
      .rd_data_a (wk_da),
      .rd_addr_b (wk_rb),
      .rd_data_b (wk_db)
   );

   assign last_idx = ML'(((ML+1)'(1) << m_ff) - (ML+1)'(1));
   assign k_last   = TIW'((((ML+1)'(1) << m_ff) >> 1) - (ML+1)'(1));
   assign kx       = ML'(k_ff);
   assign mask     = (ML'(1) << sidx_ff) - ML'(1);
   assign a_addr   = ((kx >> sidx_ff) << (int'(sidx_ff) + 1)) | (kx & mask);
   assign b_addr   = a_addr | (ML'(1) << sidx_ff);
   assign tw_idx   = TIW'((kx & mask) << ((ML - 1) - int'(sidx_ff)));
   assign br       = wk_db[2*DW-1:DW];
   assign bi       = wk_db[DW-1:0];
   assign tre_full = (PW+1)'(p_rc_ff) - (PW+1)'(p_is_ff) + RND_F;
   assign tim_full = (PW+1)'(p_rs_ff) + (PW+1)'(p_ic_ff) + RND_F;
   assign t_re     = (DW+1)'(tre_full >>> F);
   assign t_im     = (DW+1)'(tim_full >>> F);
   assign an_re    = DW'((DW+1)'(a_re_ff) + t_re);
   assign an_im    = DW'((DW+1)'(a_im_ff) + t_im);
   assign e_re     = finish(wk_da[2*DW-1:DW], inv_ff, m_ff);
   assign e_im     = finish(wk_da[DW-1:0], inv_ff, m_ff);

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_bin_re   = bin_re_ff;
   assign rsp_bin_im   = bin_im_ff;
   assign rsp_bin_last = bin_last_ff;

   always_comb begin
      state_in     = state_ff;
      m_in         = m_ff;
      inv_in       = inv_ff;
      used_in      = used_ff;
      idx_in       = idx_ff;
      cp_pend_in   = 1'b0;
      cp_idx_in    = cp_idx_ff;
      k_in         = k_ff;
      sidx_in      = sidx_ff;
      tw_c_in      = tw_c_ff;
      tw_s_in      = tw_s_ff;
      b_re_in      = b_re_ff;
      b_im_in      = b_im_ff;
      rsp_valid_in = rsp_valid_ff;
      bin_re_in    = bin_re_ff;
      bin_im_in    = bin_im_ff;
      bin_last_in  = bin_last_ff;
      back_st      = '0;
      fs_rd_addr   = idx_ff;
      wk_ra        = a_addr;
      wk_rb        = b_addr;
      wk_we        = 1'b0;
      wk_waddr     = a_addr;
      wk_wdata     = {an_re, an_im};

      // Copy writes come in the cycle after their frame store reads.
      if (cp_pend_ff) begin
         wk_we    = 1'b1;
         wk_waddr = bit_rev(cp_idx_ff, m_ff);
         if ((ML+1)'(cp_idx_ff) < used_ff) begin
            wk_wdata = {DW'(signed'(fs_rd_data[31:16])), DW'(signed'(fs_rd_data[15:0]))};
         end else begin
            wk_wdata = '0;
         end
      end

      case (state_ff)
         S_IDLE: begin
            if (job_valid) begin
               back_st.take = 1'b1;
               m_in         = MW'(job.m);
               inv_in       = job.inv;
               used_in      = (ML+1)'(job.used);
               idx_in       = '0;
               state_in     = S_COPY;
            end
         end
         S_COPY: begin
            cp_pend_in = 1'b1;
            cp_idx_in  = idx_ff;
            if (idx_ff == last_idx) begin
               back_st.unlock = 1'b1;
               state_in       = S_FLUSH;
            end else begin
               idx_in = idx_ff + ML'(1);
            end
         end
         S_FLUSH: begin
            idx_in  = '0;
            k_in    = '0;
            sidx_in = '0;
            state_in = (m_ff == '0) ? S_ERD : S_BRD;
         end
         S_BRD: begin
            tw_c_in  = tw_rom[tw_idx][24+TWB-1:24];
            tw_s_in  = inv_ff ? signed'(tw_rom[tw_idx][TWB-1:0])
                              : -signed'(tw_rom[tw_idx][TWB-1:0]);
            state_in = S_BMUL;
         end
         S_BMUL: begin
            state_in = S_BWA;
         end
         S_BWA: begin
            wk_we    = 1'b1;
            wk_waddr = a_addr;
            wk_wdata = {an_re, an_im};
            b_re_in  = DW'((DW+1)'(a_re_ff) - t_re);
            b_im_in  = DW'((DW+1)'(a_im_ff) - t_im);
            state_in = S_BWB;
         end
         S_BWB: begin
            wk_we    = 1'b1;
            wk_waddr = b_addr;
            wk_wdata = {b_re_ff, b_im_ff};
            state_in = S_BRD;
            if (k_ff == k_last) begin
               k_in = '0;
               if ((MW+1)'(sidx_ff) == (MW+1)'(m_ff) - (MW+1)'(1)) begin
                  idx_in   = '0;
                  state_in = S_ERD;
               end else begin
                  sidx_in = sidx_ff + SIW'(1);
               end
            end else begin
               k_in = k_ff + TIW'(1);
            end
         end
         S_ERD: begin
            wk_ra    = idx_ff;
            state_in = S_ECAP;
         end
         S_ECAP: begin
            wk_ra        = idx_ff;
            bin_re_in    = e_re;
            bin_im_in    = e_im;
            bin_last_in  = (idx_ff == last_idx);
            rsp_valid_in = 1'b1;
            state_in     = S_EOUT;
         end
         S_EOUT: begin
            wk_ra = idx_ff + ML'(1);
            if (rsp_ready) begin
               rsp_valid_in = 1'b0;
               if (idx_ff == last_idx) begin
                  state_in = S_IDLE;
               end else begin
                  idx_in   = idx_ff + ML'(1);
                  state_in = S_ECAP;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cp_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cp_pend_ff   <= cp_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      m_ff        <= m_in;
      inv_ff      <= inv_in;
      used_ff     <= used_in;
      idx_ff      <= idx_in;
      cp_idx_ff   <= cp_idx_in;
      k_ff        <= k_in;
      sidx_ff     <= sidx_in;
      tw_c_ff     <= tw_c_in;
      tw_s_ff     <= tw_s_in;
      b_re_ff     <= b_re_in;
      b_im_ff     <= b_im_in;
      bin_re_ff   <= bin_re_in;
      bin_im_ff   <= bin_im_in;
      bin_last_ff <= bin_last_in;
      if (state_ff == S_BMUL) begin
         p_rc_ff <= PW'(br) * PW'(tw_c_ff);
         p_is_ff <= PW'(bi) * PW'(tw_s_ff);
         p_rs_ff <= PW'(br) * PW'(tw_s_ff);
         p_ic_ff <= PW'(bi) * PW'(tw_c_ff);
         a_re_ff <= wk_da[2*DW-1:DW];
         a_im_ff <= wk_da[DW-1:0];
      end
   end

endmodule

`default_nettype wire

FILE: sv/radix2_fft_ifft_unit.sv
// Top level of the radix-2 decimation-in-time FFT / inverse FFT unit.
//
//   channel   ports                                     direction
//   req       req_valid/ready, sample_re/im, frame_end  in
//   rsp       rsp_valid/ready, bin_re/im, bin_last      out
//   csr       csr_wr_en, csr_index, csr_wdata           in, write only
//
// After frame end the compute side takes the job, copy and flush steps move the
// frame into the work memory, then each of the N/2*log2 N butterflies runs on
// the single butterfly unit through its read, multiply, write-A and write-B
// states, and after a read step the bins are emitted one at a time. The next
// frame loads while the previous one is computed. Reset is synchronous; no
// clearing pass is needed. A stalled result holds the emit loop.
`default_nettype none

module radix2_fft_ifft_unit import r2fft_pkg::*; #(
   parameter int MAX_POINTS   = 64,
   parameter int TWIDDLE_BITS = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic signed [15:0] req_sample_re,
   input  wire logic signed [15:0] req_sample_im,
   input  wire logic               req_frame_end,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic signed [23:0]      rsp_bin_re,
   output logic signed [23:0]      rsp_bin_im,
   output logic                    rsp_bin_last,
   input  wire logic               csr_wr_en,
   input  wire logic               csr_index,
   input  wire logic [2:0]         csr_wdata
);

   localparam int ML = $clog2(MAX_POINTS + 1) - 1;
   localparam int MW = $clog2(ML + 1);
   localparam int DW = 16 + ML + 2;

   logic            inverse_ff, inverse_in;
   logic [2:0]      log2_ff, log2_in;
   logic [MW-1:0]   m_eff;
   back_status_type back_st;
   logic            job_valid;
   job_type         job;
   logic            fs_wr_en;
   logic [ML-1:0]   fs_wr_addr, fs_rd_addr;
   logic [31:0]     fs_wr_data, fs_rd_data;

   assign m_eff = (int'(log2_ff) > ML) ? MW'(ML) : MW'(log2_ff);

   always_comb begin
      inverse_in = inverse_ff;
      log2_in    = log2_ff;
      if (csr_wr_en) begin
         case (int'(csr_index))
            CSR_INVERSE:     inverse_in = csr_wdata[0];
            CSR_LOG2_POINTS: log2_in    = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inverse_ff <= 1'b0;
         log2_ff    <= 3'd6;
      end else begin
         inverse_ff <= inverse_in;
         log2_ff    <= log2_in;
      end
   end

   r2fft_front #(.ML(ML), .MW(MW)) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_sample_re (req_sample_re),
      .req_sample_im (req_sample_im),
      .req_frame_end (req_frame_end),
      .cfg_inverse   (inverse_ff),
      .cfg_m         (m_eff),
      .back_st       (back_st),
      .job_valid     (job_valid),
      .job           (job),
      .fs_wr_en      (fs_wr_en),
      .fs_wr_addr    (fs_wr_addr),
      .fs_wr_data    (fs_wr_data)
   );

   r2fft_ram #(.WIDTH(32), .DEPTH(1 << ML)) u_frame (
      .clock     (clock),
      .wr_en     (fs_wr_en),
      .wr_addr   (fs_wr_addr),
      .wr_data   (fs_wr_data),
      .rd_addr_a (fs_rd_addr),
      .rd_data_a (fs_rd_data),
      .rd_addr_b (fs_rd_addr),
      .rd_data_b ()
   );

   r2fft_back #(.ML(ML), .MW(MW), .DW(DW), .TWB(TWIDDLE_BITS)) u_back (
      .clock        (clock),
      .reset        (reset),
      .job_valid    (job_valid),
      .job          (job),
      .back_st      (back_st),
      .fs_rd_addr   (fs_rd_addr),
      .fs_rd_data   (fs_rd_data),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_bin_re   (rsp_bin_re),
      .rsp_bin_im   (rsp_bin_im),
      .rsp_bin_last (rsp_bin_last)
   );

   // A frame end transfer locks the frame store until the copy is done.
   a_lock_after_end: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_frame_end) |=> !req_ready)
      else $error("input still ready after frame end");

   a_take_unlock: assert property (@(posedge clock) disable iff (reset)
      !(back_st.take && back_st.unlock))
      else $error("job taken and frame released together");

   a_write_when_open: assert property (@(posedge clock) disable iff (reset)
      fs_wr_en |-> req_ready)
      else $error("frame store written while locked");

   a_take_needs_job: assert property (@(posedge clock) disable iff (reset)
      back_st.take |-> job_valid)
      else $error("job taken with none posted");

endmodule

`default_nettype wire

FILE: verif/tb.sv
// Self-checking testbench for the radix-2 FFT/IFFT unit with a bit-true transform predictor.
`default_nettype none

module tb;
   import r2fft_pkg::*;

   typedef enum logic [1:0] {OP_SAMPLE, OP_CSR, OP_DRAIN} op_kind_type;

   typedef struct {
      op_kind_type      kind;
      logic signed [15:0] re;
      logic signed [15:0] im;
      logic               fe;
      int                 reg_idx;
      logic [2:0]         reg_val;
   } op_type;

   typedef struct {
      logic [23:0] re;
      logic [23:0] im;
      logic        last;
   } bin_type;

   localparam int MAX_LOG    = 6;
   localparam int SETTLE     = 16;
   localparam int STALL_LIM  = 20000;
   localparam longint unsigned PI_FX = 64'd3373259426;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic signed [15:0] req_sample_re;
   logic signed [15:0] req_sample_im;
   logic               req_frame_end;
   logic               rsp_valid;
   logic               rsp_ready;
   logic signed [23:0] rsp_bin_re;
   logic signed [23:0] rsp_bin_im;
   logic               rsp_bin_last;
   logic               csr_wr_en;
   logic               csr_index;
   logic [2:0]         csr_wdata;

   op_type  pending_ops[$];
   bin_type expected_bins[$];
   int      error_count = 0;

   // Predictor state: configuration copy and frame buffer.
   logic       mdl_inverse;
   logic [2:0] mdl_log2;
   longint     frame_re[64];
   longint     frame_im[64];
   int         frame_fill;

   radix2_fft_ifft_unit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_sample_re(req_sample_re), .req_sample_im(req_sample_im),
      .req_frame_end(req_frame_end),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_bin_re(rsp_bin_re), .rsp_bin_im(rsp_bin_im), .rsp_bin_last(rsp_bin_last),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // The clock starts low so that the first rising edge comes after reset is set.
   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("tb: mismatch %s got %0d want %0d", what, got, want);
      error_count++;
   endtask

   function automatic longint q30_to_q15(longint v);
      longint w;
      w = v;
      if (w < 0) w = 0;
      if (w > (64'sd1 <<< 30)) w = 64'sd1 <<< 30;
      w = (w + (64'sd1 <<< 14)) >>> 15;
      return (w > 32767) ? 32767 : w;
   endfunction

   // Twiddle cos/sin of 2*pi*k/2^m from a seven-term Taylor series in Q30.
   function automatic void twiddle_of(input int k, input int m,
                                      output longint tc_out, output longint ts_out);
      longint unsigned ph, quad, rem, ang, ang_fx, ang_sq, term_s, term_c;
      longint          sum_s, sum_c, base_c, base_s, xc, ys;
      ph = (longint'(k) << (16 - m)) & 64'hFFFF;
      quad = ph >> 14;
      rem = ph & 64'h3FFF;
      ang = (rem > 8192) ? 64'd16384 - rem : rem;
      ang_fx = (ang * PI_FX + (64'd1 << 14)) >> 15;
      ang_sq = (ang_fx * ang_fx + (64'd1 << 29)) >> 30;
      term_s = ang_fx;
      term_c = 64'd1 << 30;
      sum_s = longint'(ang_fx);
      sum_c = longint'(term_c);
      for (int t = 1; t <= 6; t++) begin
         term_s = ((term_s * ang_sq + (64'd1 << 29)) >> 30) / longint'((2*t) * (2*t + 1));
         term_c = ((term_c * ang_sq + (64'd1 << 29)) >> 30) / longint'((2*t - 1) * (2*t));
         if (t % 2 == 1) begin
            sum_s -= longint'(term_s);
            sum_c -= longint'(term_c);
         end else begin
            sum_s += longint'(term_s);
            sum_c += longint'(term_c);
         end
      end
      if (rem > 8192) begin
         base_c = sum_s;
         base_s = sum_c;
      end else begin
         base_c = sum_c;
         base_s = sum_s;
      end
      xc = q30_to_q15(base_c);
      ys = q30_to_q15(base_s);
      case (quad)
         0: begin tc_out = xc;  ts_out = ys;  end
         1: begin tc_out = -ys; ts_out = xc;  end
         2: begin tc_out = -xc; ts_out = -ys; end
         default: begin tc_out = ys; ts_out = -xc; end
      endcase
   endfunction

   function automatic longint round_half_up(longint v, int sh);
      if (sh == 0) return v;
      return (v + (64'sd1 <<< (sh - 1))) >>> sh;
   endfunction

   function automatic logic [23:0] clamp24(longint v);
      if (v > SAT_MAX) return 24'(SAT_MAX);
      if (v < SAT_MIN) return 24'(SAT_MIN);
      return 24'(v);
   endfunction

   // Runs the transform on the loaded frame and queues the N bins.
   function automatic void push_spectrum(int m, logic inv);
      longint wr[64], wi[64];
      longint c, s, sg, br, bi, tr, ti;
      int n, used, rv, span, half, a, b;
      bin_type bin;
      n = 1 << m;
      used = (frame_fill < n) ? frame_fill : n;
      for (int i = 0; i < n; i++) begin
         rv = 0;
         for (int bt = 0; bt < m; bt++) rv |= ((i >> bt) & 1) << (m - 1 - bt);
         wr[rv] = (i < used) ? frame_re[i] : 0;
         wi[rv] = (i < used) ? frame_im[i] : 0;
      end
      for (int st = 1; st <= m; st++) begin
         span = 1 << st;
         half = span >> 1;
         for (int j = 0; j < half; j++) begin
            twiddle_of(j, st, c, s);
            sg = inv ? s : -s;
            for (int base = 0; base < n; base += span) begin
               a = base + j;
               b = a + half;
               br = wr[b];
               bi = wi[b];
               tr = round_half_up(br * c - bi * sg, 15);
               ti = round_half_up(br * sg + bi * c, 15);
               wr[b] = wr[a] - tr;
               wi[b] = wi[a] - ti;
               wr[a] = wr[a] + tr;
               wi[a] = wi[a] + ti;
            end
         end
      end
      for (int i = 0; i < n; i++) begin
         if (inv) begin
            wr[i] = round_half_up(wr[i], m);
            wi[i] = round_half_up(wi[i], m);
         end
         bin.re = clamp24(wr[i]);
         bin.im = clamp24(wi[i]);
         bin.last = (i == n - 1);
         expected_bins.insert(expected_bins.size(), bin);
      end
   endfunction

   function automatic void predict_sample(op_type op);
      int m, n;
      m = (mdl_log2 > MAX_LOG) ? MAX_LOG : int'(mdl_log2);
      n = 1 << m;
      if (frame_fill < n) begin
         frame_re[frame_fill] = op.re;
         frame_im[frame_fill] = op.im;
         frame_fill++;
      end
      if (op.fe) begin
         push_spectrum(m, mdl_inverse);
         frame_fill = 0;
      end
   endfunction

   // Driver.
   op_type cur_op;
   int     send_gap;
   int     settle_cnt;

   always @(posedge clock) begin
      logic   nv, nwr;
      op_type hd;
      nv = req_valid;
      nwr = 1'b0;
      if (reset) begin
         req_valid <= 1'b0;
         csr_wr_en <= 1'b0;
         send_gap = 0;
         settle_cnt = 0;
      end else begin
         if (req_valid && req_ready) begin
            predict_sample(cur_op);
            nv = 1'b0;
            send_gap = $urandom_range(0, 5);
         end
         if (!nv) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (pending_ops.size() != 0) begin
               hd = pending_ops[0];
               if (hd.kind == OP_SAMPLE) begin
                  void'(pending_ops.pop_front());
                  cur_op = hd;
                  nv = 1'b1;
                  req_sample_re <= hd.re;
                  req_sample_im <= hd.im;
                  req_frame_end <= hd.fe;
               end else if (expected_bins.size() == 0) begin
                  // Let the unit go fully quiet before touching a register.
                  if (settle_cnt < SETTLE) begin
                     settle_cnt++;
                  end else begin
                     settle_cnt = 0;
                     void'(pending_ops.pop_front());
                     if (hd.kind == OP_CSR) begin
                        nwr = 1'b1;
                        csr_index <= 1'(hd.reg_idx);
                        csr_wdata <= hd.reg_val;
                        if (hd.reg_idx == CSR_INVERSE) mdl_inverse = hd.reg_val[0];
                        else mdl_log2 = hd.reg_val;
                     end
                  end
               end
            end
         end
         req_valid <= nv;
         csr_wr_en <= nwr;
      end
   end

   // Monitor and checker.
   int recv_stall;

   always @(posedge clock) begin
      bin_type want;
      logic    nr;
      nr = rsp_ready;
      if (reset) begin
         rsp_ready <= 1'b0;
         recv_stall = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_bins.size() == 0) begin
               report_mismatch("unexpected bin, re", rsp_bin_re, 0);
            end else begin
               want = expected_bins.pop_front();
               if (rsp_bin_re !== want.re)
                  report_mismatch("bin_re", rsp_bin_re, $signed(want.re));
               if (rsp_bin_im !== want.im)
                  report_mismatch("bin_im", rsp_bin_im, $signed(want.im));
               if (rsp_bin_last !== want.last)
                  report_mismatch("bin_last", rsp_bin_last, want.last);
            end
            recv_stall = $urandom_range(0, 5);
         end
         if (recv_stall > 0) begin
            recv_stall--;
            nr = 1'b0;
         end else begin
            nr = 1'b1;
         end
         rsp_ready <= nr;
      end
   end

   // Watchdog on cycles without any transfer.
   int idle_cycles = 0;

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_wr_en || reset)
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= STALL_LIM) begin
         $display("tb: errors");
         $finish;
      end
   end

   task automatic add_sample(input logic signed [15:0] re, input logic signed [15:0] im,
                             input logic fe);
      op_type op;
      op.kind = OP_SAMPLE;
      op.re = re;
      op.im = im;
      op.fe = fe;
      op.reg_idx = 0;
      op.reg_val = '0;
      pending_ops.insert(pending_ops.size(), op);
   endtask

   task automatic add_csr(input int idx, input logic [2:0] val);
      op_type op;
      op.kind = OP_CSR;
      op.re = '0;
      op.im = '0;
      op.fe = 1'b0;
      op.reg_idx = idx;
      op.reg_val = val;
      pending_ops.insert(pending_ops.size(), op);
   endtask

   task automatic add_drain();
      op_type op;
      op.kind = OP_DRAIN;
      op.re = '0;
      op.im = '0;
      op.fe = 1'b0;
      op.reg_idx = 0;
      op.reg_val = '0;
      pending_ops.insert(pending_ops.size(), op);
   endtask

   initial begin
      int sent, lg, flen, npts;
      req_valid = 1'b0;
      req_sample_re = '0;
      req_sample_im = '0;
      req_frame_end = 1'b0;
      rsp_ready = 1'b0;
      csr_wr_en = 1'b0;
      csr_index = 1'b0;
      csr_wdata = '0;
      mdl_inverse = 1'b0;
      mdl_log2 = 3'd6;
      frame_fill = 0;
      reset = 1'b1;

      // Default setting: a zero-padded 64-point forward frame from one impulse.
      add_sample(16'sh7FFF, 16'sh8000, 1'b1);
      // Length one passes the sample through; a second sample overflows the frame.
      add_csr(CSR_LOG2_POINTS, 3'd0);
      add_sample(16'sh8000, 16'sh7FFF, 1'b1);
      add_sample(16'sh7FFF, 16'sh8000, 1'b0);
      add_sample(16'sh1234, -16'sh0001, 1'b1);
      // Two-point inverse on the extremes.
      add_csr(CSR_INVERSE, 3'd1);
      add_csr(CSR_LOG2_POINTS, 3'd1);
      add_sample(16'sh8000, 16'sh8000, 1'b0);
      add_sample(16'sh7FFF, 16'sh7FFF, 1'b1);
      // Oversized length falls back to 64 points.
      add_csr(CSR_INVERSE, 3'd0);
      add_csr(CSR_LOG2_POINTS, 3'd7);
      add_sample(16'sh7FFF, 16'sh0000, 1'b0);
      add_sample(16'sh0000, 16'sh7FFF, 1'b0);
      add_sample(16'sh8000, 16'sh8000, 1'b1);
      // The length shrinks in the middle of a frame.
      add_csr(CSR_LOG2_POINTS, 3'd3);
      for (int i = 0; i < 5; i++) add_sample(16'(i * 7000 - 16000), 16'(20000 - i * 9000), 1'b0);
      add_csr(CSR_LOG2_POINTS, 3'd2);
      add_sample(16'sh4000, -16'sh4000, 1'b1);
      // Full-scale negative inverse frame of four.
      add_csr(CSR_INVERSE, 3'd1);
      for (int i = 0; i < 4; i++) add_sample(16'sh8000, 16'sh8000, i == 3);

      // Random frames: mostly short lengths, a few full ones.
      sent = 0;
      while (sent < 88) begin
         if ($urandom_range(0, 2) == 0) add_csr(CSR_INVERSE, 3'($urandom_range(0, 1)));
         lg = $urandom_range(0, 7);
         if (lg >= 5 && $urandom_range(0, 9) < 7) lg = $urandom_range(0, 4);
         add_csr(CSR_LOG2_POINTS, 3'(lg));
         npts = 1 << ((lg > MAX_LOG) ? MAX_LOG : lg);
         flen = $urandom_range(1, npts + 2);
         if (flen > 94 - sent) flen = 94 - sent;
         for (int i = 0; i < flen; i++) begin
            add_sample(16'($urandom), 16'($urandom), i == flen - 1);
            sent++;
         end
         if ($urandom_range(0, 5) == 0) add_drain();
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      do @(posedge clock);
      while (pending_ops.size() != 0 || req_valid || expected_bins.size() != 0);
      repeat (200) @(posedge clock);
      if (error_count == 0 && expected_bins.size() == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

endmodule

`default_nettype wire

FILE: files.f
sv/r2fft_pkg.sv
sv/r2fft_ram.sv
sv/r2fft_front.sv
sv/r2fft_back.sv
sv/radix2_fft_ifft_unit.sv
verif/tb.sv
